// ----- rtl/box_overlap_ratio_core_assert.svh -----
// Assertion macros used by the box overlap ratio top level.
`ifndef BOX_OVERLAP_RATIO_CORE_ASSERT_SVH
`define BOX_OVERLAP_RATIO_CORE_ASSERT_SVH

// Checked on every rising edge outside of reset.
`define BOR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define BOR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/bor_pkg.sv -----
// Shared widths, constants and stage payload types for the box overlap ratio core.
package bor_pkg;

    localparam int SIZE_BITS = 15;
    localparam int AREA_W    = 2 * SIZE_BITS;
    localparam int UNI_W     = AREA_W + 1;
    localparam int PCT_BITS  = 7;
    localparam int NUM_W     = AREA_W + PCT_BITS;
    localparam int PCT_SCALE = 100;

    typedef logic [SIZE_BITS-1:0] t_size;

    // Clipped intersection extents plus the four box sides.
    typedef struct packed {
        t_size iw;
        t_size ih;
        t_size tw;
        t_size th;
        t_size cw;
        t_size ch;
    } t_ext;

    // State handed along the divider cells.
    typedef struct packed {
        logic [NUM_W-1:0]    rem;
        logic [UNI_W-1:0]    den;
        logic [PCT_BITS-1:0] quo;
        logic                empty;
    } t_div;

endpackage

// ----- rtl/bor_isect.sv -----
// Intersection stage: clipped overlap width and height of the two boxes.
module bor_isect import bor_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [COORD_BITS-1:0] i_track_left,
    input  logic signed [COORD_BITS-1:0] i_track_top,
    input  t_size                        i_track_width,
    input  t_size                        i_track_height,
    input  logic signed [COORD_BITS-1:0] i_cand_left,
    input  logic signed [COORD_BITS-1:0] i_cand_top,
    input  t_size                        i_cand_width,
    input  t_size                        i_cand_height,
    output logic                         o_valid,
    input  logic                         i_ready,
    output t_ext                         o_ext
);

    localparam int MAX_W = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;
    localparam int EW    = MAX_W + 3;

    logic          r_valid;
    t_ext          r_ext;
    t_ext          n_ext;
    logic signed [EW-1:0] w_tl, w_tt, w_cl, w_ct;
    logic signed [EW-1:0] w_tr, w_tb, w_cr, w_cb;
    logic signed [EW-1:0] w_ix, w_iy, w_iw, w_ih;

    always_comb begin
        w_tl = EW'(i_track_left);
        w_tt = EW'(i_track_top);
        w_cl = EW'(i_cand_left);
        w_ct = EW'(i_cand_top);
        w_tr = w_tl + signed'(EW'(i_track_width));
        w_tb = w_tt + signed'(EW'(i_track_height));
        w_cr = w_cl + signed'(EW'(i_cand_width));
        w_cb = w_ct + signed'(EW'(i_cand_height));
        w_ix = (w_tl > w_cl) ? w_tl : w_cl;
        w_iy = (w_tt > w_ct) ? w_tt : w_ct;
        w_iw = ((w_tr < w_cr) ? w_tr : w_cr) - w_ix;
        w_ih = ((w_tb < w_cb) ? w_tb : w_cb) - w_iy;
        // A positive extent never exceeds the narrower box, so it fits a size field.
        n_ext.iw = (w_iw > 0) ? w_iw[SIZE_BITS-1:0] : '0;
        n_ext.ih = (w_ih > 0) ? w_ih[SIZE_BITS-1:0] : '0;
        n_ext.tw = i_track_width;
        n_ext.th = i_track_height;
        n_ext.cw = i_cand_width;
        n_ext.ch = i_cand_height;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_ext <= n_ext;
        end
    end

    assign o_valid = r_valid;
    assign o_ext   = r_ext;

endmodule

// ----- rtl/bor_area.sv -----
// Area stages: the three products, then union area and scaled intersection.
module bor_area import bor_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_ext i_ext,
    output logic o_valid,
    input  logic i_ready,
    output t_div o_div
);

    logic              r_prod_valid;
    logic [AREA_W-1:0] r_inter, r_track_area, r_cand_area;
    logic              w_prod_ready;
    logic              r_valid;
    t_div              r_div;
    t_div              n_div;
    logic [UNI_W-1:0]  w_union;

    assign w_prod_ready = !r_valid || i_ready;
    assign o_ready      = !r_prod_valid || w_prod_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
        end else if (o_ready) begin
            r_prod_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_inter      <= AREA_W'(i_ext.iw) * AREA_W'(i_ext.ih);
            r_track_area <= AREA_W'(i_ext.tw) * AREA_W'(i_ext.th);
            r_cand_area  <= AREA_W'(i_ext.cw) * AREA_W'(i_ext.ch);
        end
    end

    always_comb begin
        // The intersection lies inside both boxes, so the union never goes negative.
        w_union     = UNI_W'(r_track_area) + UNI_W'(r_cand_area) - UNI_W'(r_inter);
        n_div.rem   = NUM_W'(r_inter) * NUM_W'(PCT_SCALE);
        n_div.den   = w_union;
        n_div.quo   = '0;
        n_div.empty = (w_union == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_prod_ready) begin
            r_valid <= r_prod_valid;
        end
        if (w_prod_ready && r_prod_valid) begin
            r_div <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;

endmodule

// ----- rtl/bor_div_cell.sv -----
// One restoring-division cell: resolves a single quotient bit per transfer.
module bor_div_cell import bor_pkg::*; #(
    parameter int BIT = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_div i_div,
    output logic o_valid,
    input  logic i_ready,
    output t_div o_div
);

    logic             r_valid;
    t_div             r_div;
    t_div             n_div;
    logic [NUM_W:0]   w_rem;
    logic [NUM_W:0]   w_dsh;
    logic [NUM_W:0]   w_diff;
    logic             w_ge;

    always_comb begin
        w_rem  = (NUM_W + 1)'(i_div.rem);
        w_dsh  = (NUM_W + 1)'(i_div.den) << BIT;
        w_diff = w_rem - w_dsh;
        w_ge   = (w_rem >= w_dsh);
        n_div.rem   = w_ge ? w_diff[NUM_W-1:0] : i_div.rem;
        n_div.den   = i_div.den;
        // An empty union yields a zero quotient.
        n_div.quo   = {i_div.quo[PCT_BITS-2:0], w_ge && !i_div.empty};
        n_div.empty = i_div.empty;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_div <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;

endmodule

// ----- rtl/box_overlap_ratio_core.sv -----
// Top level of the box overlap ratio core: intersection over union as a percent.
//
// Takes one box pair per cycle while s_axis_tready is high and returns
// floor(100 * intersection / union) for each pair in input order. An item passes a
// register for the intersection extents, one for the three area products, one for the
// union and the scaled intersection, and one in each of the seven divider cells that
// resolve the percent one bit at a time, most significant bit first. Every stage holds
// its own valid bit, so the core keeps taking pairs while a finished result waits at
// the output; it stops only once every stage is full. A pair whose union area is zero
// comes out as 0 percent with the empty flag set.
`include "box_overlap_ratio_core_assert.svh"

module box_overlap_ratio_core import bor_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // track_left, track_top, track_width, track_height,
    // cand_left, cand_top, cand_width, cand_height; zero padded to bytes.
    input  logic [((4*COORD_BITS+4*SIZE_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // overlap_percent, one zero pad bit.
    output logic [7:0]            m_axis_tdata,
    // union_empty.
    output logic                  m_axis_tuser
);

    localparam int TL_LO = 0;
    localparam int TT_LO = COORD_BITS;
    localparam int TW_LO = 2 * COORD_BITS;
    localparam int TH_LO = TW_LO + SIZE_BITS;
    localparam int CL_LO = TH_LO + SIZE_BITS;
    localparam int CT_LO = CL_LO + COORD_BITS;
    localparam int CW_LO = CT_LO + COORD_BITS;
    localparam int CH_LO = CW_LO + SIZE_BITS;

    logic isect_valid, isect_ready;
    t_ext isect_ext;

    logic cell_valid [PCT_BITS+1];
    logic cell_ready [PCT_BITS+1];
    t_div cell_div   [PCT_BITS+1];

    bor_isect #(
        .COORD_BITS (COORD_BITS)
    ) u_isect (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_track_left   (s_axis_tdata[TL_LO +: COORD_BITS]),
        .i_track_top    (s_axis_tdata[TT_LO +: COORD_BITS]),
        .i_track_width  (s_axis_tdata[TW_LO +: SIZE_BITS]),
        .i_track_height (s_axis_tdata[TH_LO +: SIZE_BITS]),
        .i_cand_left    (s_axis_tdata[CL_LO +: COORD_BITS]),
        .i_cand_top     (s_axis_tdata[CT_LO +: COORD_BITS]),
        .i_cand_width   (s_axis_tdata[CW_LO +: SIZE_BITS]),
        .i_cand_height  (s_axis_tdata[CH_LO +: SIZE_BITS]),
        .o_valid        (isect_valid),
        .i_ready        (isect_ready),
        .o_ext          (isect_ext)
    );

    bor_area u_area (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (isect_valid),
        .o_ready (isect_ready),
        .i_ext   (isect_ext),
        .o_valid (cell_valid[0]),
        .i_ready (cell_ready[0]),
        .o_div   (cell_div[0])
    );

    for (genvar k = 0; k < PCT_BITS; k++) begin : g_cell
        bor_div_cell #(
            .BIT (PCT_BITS - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (cell_valid[k]),
            .o_ready (cell_ready[k]),
            .i_div   (cell_div[k]),
            .o_valid (cell_valid[k+1]),
            .i_ready (cell_ready[k+1]),
            .o_div   (cell_div[k+1])
        );
    end

    assign cell_ready[PCT_BITS] = m_axis_tready;
    assign m_axis_tvalid        = cell_valid[PCT_BITS];
    assign m_axis_tdata         = {1'b0, cell_div[PCT_BITS].quo};
    assign m_axis_tuser         = cell_div[PCT_BITS].empty;

    `BOR_ASSERT(a_empty_zero, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 8'd0, "empty union must give zero percent")
    `BOR_ASSERT(a_pct_range, m_axis_tvalid |-> m_axis_tdata <= 8'(PCT_SCALE), "percent above full scale")
    `BOR_ASSERT_ALWAYS(a_ready_free, (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready, "core stalls input with a free output slot")

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the box overlap ratio core: directed and random box pairs.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bor_pkg::*;

    localparam int COORD_BITS    = 16;
    localparam int TDATA_W       = ((4*COORD_BITS + 4*SIZE_BITS + 7)/8)*8;
    localparam int PAD_W         = TDATA_W - 4*COORD_BITS - 4*SIZE_BITS;
    localparam int SETTLE_CYCLES = 25;
    localparam int STALL_CYCLES  = 80;
    localparam int PHASE_ITEMS   = 530;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    // Mirrors the tdata layout, highest field first.
    typedef struct packed {
        logic [PAD_W-1:0] pad;
        t_size            cand_height;
        t_size            cand_width;
        t_coord           cand_top;
        t_coord           cand_left;
        t_size            track_height;
        t_size            track_width;
        t_coord           track_top;
        t_coord           track_left;
    } box_pair_t;

    typedef struct packed {
        logic [PCT_BITS-1:0] percent;
        logic                union_empty;
    } overlap_t;

    typedef struct {
        box_pair_t pair;
        bit        typed;
        overlap_t  want;
    } pair_row_t;

    typedef enum int {
        SHAPE_NEAR,
        SHAPE_SIMILAR,
        SHAPE_ANY,
        SHAPE_FLAT,
        SHAPE_TOUCH
    } shape_e;

    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [7:0]         m_axis_tdata;
    logic               m_axis_tuser;

    pair_row_t offered_q[$];
    overlap_t  expected_q[$];
    pair_row_t dir_tbl[$];
    pair_row_t offered;
    overlap_t  want;
    int        error_count = 0;
    int        tx_idle_pct = 0;
    int        rx_idle_pct = 0;
    int        stall_left  = 0;

    box_overlap_ratio_core #(
        .COORD_BITS(COORD_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Expected percent and empty flag for one box pair.
    function automatic overlap_t box_iou_percent(box_pair_t p);
        longint tl, tt, tw, th, cl, ct, cw, ch;
        longint ix, iy, iw, ih;
        longint unsigned inter, uni, pct;
        overlap_t r;
        tl = $signed(p.track_left);
        tt = $signed(p.track_top);
        cl = $signed(p.cand_left);
        ct = $signed(p.cand_top);
        tw = p.track_width;
        th = p.track_height;
        cw = p.cand_width;
        ch = p.cand_height;
        ix = (tl > cl) ? tl : cl;
        iy = (tt > ct) ? tt : ct;
        iw = ((tl + tw < cl + cw) ? tl + tw : cl + cw) - ix;
        ih = ((tt + th < ct + ch) ? tt + th : ct + ch) - iy;
        inter = 0;
        if (iw > 0 && ih > 0) begin
            inter = iw * ih;
        end
        uni = tw * th + cw * ch - inter;
        if (uni == 0) begin
            r.percent     = '0;
            r.union_empty = 1'b1;
        end else begin
            pct = (PCT_SCALE * inter) / uni;
            if (pct > PCT_SCALE) begin
                pct = PCT_SCALE;
            end
            r.percent     = pct[PCT_BITS-1:0];
            r.union_empty = 1'b0;
        end
        return r;
    endfunction

    function automatic pair_row_t dir_row(int tl, int tt, int tw, int th,
                                          int cl, int ct, int cw, int ch,
                                          bit typed = 1'b0, int pct = 0, bit empty = 1'b0);
        pair_row_t r;
        r.pair              = '0;
        r.pair.track_left   = t_coord'(tl);
        r.pair.track_top    = t_coord'(tt);
        r.pair.track_width  = t_size'(tw);
        r.pair.track_height = t_size'(th);
        r.pair.cand_left    = t_coord'(cl);
        r.pair.cand_top     = t_coord'(ct);
        r.pair.cand_width   = t_size'(cw);
        r.pair.cand_height  = t_size'(ch);
        r.typed             = typed;
        r.want.percent      = PCT_BITS'(pct);
        r.want.union_empty  = empty;
        return r;
    endfunction

    function automatic t_size pick_size();
        int sel;
        sel = $urandom_range(99);
        if (sel < 80) begin
            return t_size'($urandom_range(400));
        end
        if (sel < 95) begin
            return t_size'($urandom);
        end
        return sel[0] ? '1 : '0;
    endfunction

    // Offset of the new box edge that keeps the two extents overlapping or close.
    function automatic int near_offset(t_size track_ext, t_size cand_ext);
        return int'($urandom_range(int'(track_ext) + int'(cand_ext) + 2)) - int'(cand_ext) - 1;
    endfunction

    function automatic pair_row_t random_row();
        pair_row_t r;
        box_pair_t p;
        shape_e    shape;
        int        sel;
        p = '0;
        sel = $urandom_range(99);
        shape = (sel < 45) ? SHAPE_NEAR :
                (sel < 60) ? SHAPE_SIMILAR :
                (sel < 80) ? SHAPE_ANY :
                (sel < 90) ? SHAPE_FLAT : SHAPE_TOUCH;
        p.track_left   = t_coord'($urandom);
        p.track_top    = t_coord'($urandom);
        p.track_width  = pick_size();
        p.track_height = pick_size();
        p.cand_width   = pick_size();
        p.cand_height  = pick_size();
        p.cand_left = t_coord'(int'(p.track_left) + near_offset(p.track_width, p.cand_width));
        p.cand_top  = t_coord'(int'(p.track_top) + near_offset(p.track_height, p.cand_height));
        case (shape)
            SHAPE_SIMILAR: begin
                p.cand_width  = t_size'(int'(p.track_width) + int'($urandom_range(4)) - 2);
                p.cand_height = t_size'(int'(p.track_height) + int'($urandom_range(4)) - 2);
                p.cand_left   = t_coord'(int'(p.track_left) + int'($urandom_range(6)) - 3);
                p.cand_top    = t_coord'(int'(p.track_top) + int'($urandom_range(6)) - 3);
            end
            SHAPE_ANY: begin
                p.track_width  = t_size'($urandom);
                p.track_height = t_size'($urandom);
                p.cand_left    = t_coord'($urandom);
                p.cand_top     = t_coord'($urandom);
                p.cand_width   = t_size'($urandom);
                p.cand_height  = t_size'($urandom);
            end
            SHAPE_FLAT: begin
                if ($urandom_range(1)) p.track_width = '0;
                else p.track_height = '0;
                // Now and then both boxes are flat, which leaves an empty union.
                if ($urandom_range(3) == 0) begin
                    if ($urandom_range(1)) p.cand_width = '0;
                    else p.cand_height = '0;
                end
            end
            SHAPE_TOUCH: begin
                if ($urandom_range(1)) begin
                    p.cand_left = t_coord'(int'(p.track_left) + int'(p.track_width));
                end else begin
                    p.cand_top = t_coord'(int'(p.track_top) - int'(p.cand_height));
                end
            end
            default: begin
            end
        endcase
        r.pair  = p;
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    task automatic send_pair(pair_row_t row);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        offered_q.push_back(row);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_W'(row.pair);
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        wait (expected_q.size() == 0);
    endtask

    // Receiver: random back-pressure, or a counted hold-off when one is requested.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (offered_q.size() == 0) begin
                    $display("%0t: input transfer with no pair on offer", $time);
                    error_count++;
                end else begin
                    offered = offered_q.pop_front();
                    expected_q.push_back(offered.typed ? offered.want
                                         : box_iou_percent(box_pair_t'(s_axis_tdata)));
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected output transfer, percent %0d empty %0b",
                             $time, m_axis_tdata[PCT_BITS-1:0], m_axis_tuser);
                    error_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (m_axis_tdata[PCT_BITS-1:0] !== want.percent) begin
                        $display("%0t: overlap_percent mismatch, expected %0d, actual %0d",
                                 $time, want.percent, m_axis_tdata[PCT_BITS-1:0]);
                        error_count++;
                    end
                    if (m_axis_tuser !== want.union_empty) begin
                        $display("%0t: union_empty mismatch, expected %0b, actual %0b",
                                 $time, want.union_empty, m_axis_tuser);
                        error_count++;
                    end
                end
            end
        end
    end

    initial begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_rst_n       = 1'b0;

        dir_tbl.push_back(dir_row(0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 0, 1'b1));
        dir_tbl.push_back(dir_row(0, 0, 10, 10, 0, 0, 10, 10, 1'b1, 100));
        dir_tbl.push_back(dir_row(-32768, -32768, 32767, 32767,
                                  -32768, -32768, 32767, 32767, 1'b1, 100));
        dir_tbl.push_back(dir_row(32767, 32767, 32767, 32767,
                                  32767, 32767, 32767, 32767, 1'b1, 100));
        dir_tbl.push_back(dir_row(0, 0, 10, 10, 20, 20, 10, 10, 1'b1, 0));
        dir_tbl.push_back(dir_row(0, 0, 10, 10, 10, 0, 10, 10, 1'b1, 0));
        dir_tbl.push_back(dir_row(0, 0, 10, 10, 0, 10, 10, 10, 1'b1, 0));
        dir_tbl.push_back(dir_row(0, 0, 0, 10, 0, 0, 20, 0, 1'b1, 0, 1'b1));
        dir_tbl.push_back(dir_row(0, 0, 32767, 0, 5, 5, 0, 32767, 1'b1, 0, 1'b1));
        dir_tbl.push_back(dir_row(5, 5, 0, 0, 0, 0, 10, 10, 1'b1, 0));
        dir_tbl.push_back(dir_row(-32768, -32768, 32767, 32767,
                                  32767, 32767, 32767, 32767, 1'b1, 0));
        dir_tbl.push_back(dir_row(32767, 32767, 32767, 32767,
                                  -32768, -32768, 32767, 32767, 1'b1, 0));
        dir_tbl.push_back(dir_row(0, 0, 10, 0, 0, 0, 10, 10, 1'b1, 0));
        dir_tbl.push_back(dir_row(0, 0, 10, 10, 0, 0, 5, 5, 1'b1, 25));
        dir_tbl.push_back(dir_row(-10, -10, 20, 20, -5, -5, 10, 10, 1'b1, 25));
        dir_tbl.push_back(dir_row(0, 0, 100, 100, 0, 0, 100, 99, 1'b1, 99));
        dir_tbl.push_back(dir_row(0, 0, 32767, 32767, 100, 100, 1, 1, 1'b1, 0));
        dir_tbl.push_back(dir_row(0, 0, 10, 10, 5, 0, 10, 10));
        dir_tbl.push_back(dir_row(-32768, 0, 32767, 1, -1, 0, 1, 1));
        dir_tbl.push_back(dir_row(100, -200, 7, 3, 98, -199, 5, 9));
        dir_tbl.push_back(dir_row(0, 0, 32767, 32767, 16384, 0, 32767, 32767));
        dir_tbl.push_back(dir_row(0, 0, 3, 3, 1, 1, 1, 1));
        dir_tbl.push_back(dir_row(-1, -1, 2, 2, 0, 0, 32767, 32767));

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 25;
        rx_idle_pct = 61;
        foreach (dir_tbl[i]) begin
            send_pair(dir_tbl[i]);
        end
        repeat (PHASE_ITEMS) send_pair(random_row());
        drain_results();

        tx_idle_pct = 61;
        rx_idle_pct = 25;
        repeat (PHASE_ITEMS) send_pair(random_row());
        drain_results();

        // Hold the output off long enough that every stage fills and the input stalls.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        stall_left  = STALL_CYCLES;
        repeat (PHASE_ITEMS + 10) send_pair(random_row());
        drain_results();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("status: fail");
        $finish;
    end

endmodule
